### design/kwm_pkg.sv
`default_nettype none

package kwm_pkg;

  // default build size
  localparam int NUM_LISTS_DEF  = 8;
  localparam int LIST_DEPTH_DEF = 64;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         list_index;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic [2:0]         source_list;
  } rsp_t;

endpackage

`default_nettype wire

### design/kwm_list_ram.sv
`default_nettype none

module kwm_list_ram #(
  parameter int AW = 9,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

### design/kwm_ptr_table.sv
`default_nettype none

module kwm_ptr_table #(
  parameter int AW = 3,
  parameter int DW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // an entry without its valid bit reads as all pointers and count zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (clr) begin
        vld <= '0;
      end
      if (we) begin
        vld[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q   <= mem[ra];
    rd_vld <= vld[ra];
  end

  assign rd = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

### design/k_way_sorted_merge_core.sv
`default_nettype none

// channel   direction  handshake             payload
// req       in         req_valid/req_ready   kwm_pkg::req_t (cmd, list_index, value)
// rsp       out        rsp_valid/rsp_ready   kwm_pkg::rsp_t (status, merged_value, source_list)
//
// append is accepted, then checks the pointer entry and writes; clear, unused
// commands and appends to a list index past NUM_LISTS finish in the accept cycle
// pop scans the heads one list per cycle through the pointer table and then
// the list memory, then does the pointer write-back
// reset empties every list at once through the pointer valid bits; no clearing pass
// one request is worked at a time; the next one is taken while a result waits
// in the output register, and finishes once rsp_ready frees that register

module k_way_sorted_merge_core #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  kwm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kwm_pkg::rsp_t rsp
);

  import kwm_pkg::*;

  localparam int LW = $clog2(NUM_LISTS);
  localparam int PW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int EW = 2 * PW + CW;
  localparam int AW = LW + PW;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_SCAN   = 5'b00100,
    S_POP_WR = 5'b01000,
    S_HOLD   = 5'b10000
  } state_t;

  function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
    slot_next = (p == PW'(LIST_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  state_t state, state_next;

  // latched request
  logic [LW-1:0] cur_k;
  logic [31:0]   cur_value;

  // head scan: issue counter, pointer read stage, data read stage
  logic [LW-1:0] iss_k;
  logic          iss_done;
  logic          s1_v;
  logic [LW-1:0] s1_k;
  logic          s2_v;
  logic [LW-1:0] s2_k;
  logic [PW-1:0] s2_rp;
  logic [PW-1:0] s2_wp;
  logic [CW-1:0] s2_cnt;

  // running minimum
  logic          found;
  logic [LW-1:0] best_k;
  logic [31:0]   best_val;
  logic [PW-1:0] best_rp;
  logic [PW-1:0] best_wp;
  logic [CW-1:0] best_cnt;

  rsp_t hold_rsp;

  // memory ports
  logic [LW-1:0] ptr_ra;
  logic [EW-1:0] ptr_rd;
  logic          ptr_we;
  logic [LW-1:0] ptr_wa;
  logic [EW-1:0] ptr_wd;
  logic          ptr_clr;
  logic [AW-1:0] ram_ra;
  logic [31:0]   ram_rd;
  logic          ram_we;
  logic [AW-1:0] ram_wa;

  // unpacked pointer entry {read pointer, write pointer, fill count}
  logic [PW-1:0] pt_rp;
  logic [PW-1:0] pt_wp;
  logic [CW-1:0] pt_cnt;

  logic          acc;
  logic          out_free;
  logic [LW-1:0] req_k;
  logic          req_in_range;
  logic          app_full;
  logic          scan_last;
  logic          upd;
  logic          done;
  rsp_t          done_rsp;

  assign pt_rp  = ptr_rd[EW-1 -: PW];
  assign pt_wp  = ptr_rd[CW+PW-1 -: PW];
  assign pt_cnt = ptr_rd[CW-1:0];

  assign req_ready    = (state == S_IDLE);
  assign acc          = req_valid && req_ready;
  assign out_free     = !rsp_valid || rsp_ready;
  assign req_k        = LW'(req.list_index);
  assign req_in_range = {29'd0, req.list_index} < 32'(NUM_LISTS);
  assign app_full     = (pt_cnt == CW'(LIST_DEPTH));
  assign scan_last    = s2_v && (s2_k == LW'(NUM_LISTS - 1));

  // new head beats the current best only when strictly smaller
  assign upd = s2_v && (s2_cnt != '0) && (!found || ($signed(ram_rd) < $signed(best_val)));

  // pointer table: accept cycle reads the target list or list 0, scan reads iss_k
  always_comb begin
    if (state == S_IDLE) begin
      ptr_ra = (req.cmd == CMD_POP) ? '0 : req_k;
    end else begin
      ptr_ra = iss_k;
    end
  end

  assign ptr_clr = acc && (req.cmd == CMD_CLEAR);
  assign ptr_we  = ((state == S_APPEND) && !app_full) || ((state == S_POP_WR) && found);
  assign ptr_wa  = (state == S_APPEND) ? cur_k : best_k;
  assign ptr_wd  = (state == S_APPEND) ? {pt_rp, slot_next(pt_wp), pt_cnt + CW'(1)}
                                       : {slot_next(best_rp), best_wp, best_cnt - CW'(1)};

  assign ram_ra = {s1_k, pt_rp};
  assign ram_we = (state == S_APPEND) && !app_full;
  assign ram_wa = {cur_k, pt_wp};

  kwm_ptr_table #(
    .AW (LW),
    .DW (EW)
  ) u_ptr_table (
    .clk (clk),
    .rst (rst),
    .clr (ptr_clr),
    .ra  (ptr_ra),
    .rd  (ptr_rd),
    .we  (ptr_we),
    .wa  (ptr_wa),
    .wd  (ptr_wd)
  );

  kwm_list_ram #(
    .AW (AW),
    .DW (32)
  ) u_list_ram (
    .clk (clk),
    .ra  (ram_ra),
    .rd  (ram_rd),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (cur_value)
  );

  // completion and next state
  always_comb begin
    done       = 1'b0;
    done_rsp   = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.cmd)
            CMD_APPEND: begin
              if (req_in_range) begin
                state_next = S_APPEND;
              end else begin
                done            = 1'b1;
                done_rsp.status = ST_FULL;
              end
            end
            CMD_POP: begin
              state_next = S_SCAN;
            end
            default: begin
              // clear and the unused command answer ok at once
              done = 1'b1;
            end
          endcase
        end
      end
      S_APPEND: begin
        done            = 1'b1;
        done_rsp.status = app_full ? ST_FULL : ST_OK;
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_POP_WR;
        end
      end
      S_POP_WR: begin
        done = 1'b1;
        if (found) begin
          done_rsp.merged_value = best_val;
          done_rsp.source_list  = 3'(best_k);
        end else begin
          done_rsp.status = ST_EMPTY;
        end
      end
      S_HOLD: begin
        done     = 1'b1;
        done_rsp = hold_rsp;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (done) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      iss_done  <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;

      if (done && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (acc && (req.cmd == CMD_POP)) begin
        // list 0 pointer read goes out this cycle
        s1_v     <= 1'b1;
        s2_v     <= 1'b0;
        iss_done <= 1'b0;
        found    <= 1'b0;
      end else if (state == S_SCAN) begin
        s1_v <= !iss_done;
        s2_v <= s1_v;
        if (!iss_done && (iss_k == LW'(NUM_LISTS - 1))) begin
          iss_done <= 1'b1;
        end
        if (upd) begin
          found <= 1'b1;
        end
      end else begin
        s1_v <= 1'b0;
        s2_v <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (done && out_free) begin
      rsp <= done_rsp;
    end
    if (done && !out_free) begin
      hold_rsp <= done_rsp;
    end
    if (acc) begin
      cur_k     <= req_k;
      cur_value <= req.value;
      s1_k      <= '0;
      iss_k     <= LW'(1);
    end else if (state == S_SCAN) begin
      s1_k <= iss_k;
      if (!iss_done && (iss_k != LW'(NUM_LISTS - 1))) begin
        iss_k <= iss_k + LW'(1);
      end
      // pointer entry of list s1_k lines up with its head read
      s2_k   <= s1_k;
      s2_rp  <= pt_rp;
      s2_wp  <= pt_wp;
      s2_cnt <= pt_cnt;
      if (upd) begin
        best_k   <= s2_k;
        best_val <= ram_rd;
        best_rp  <= s2_rp;
        best_wp  <= s2_wp;
        best_cnt <= s2_cnt;
      end
    end
  end

  // a winning list always holds at least one value
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_WR && found) |-> best_cnt != '0)
    else $error("pop write-back on an empty list");

  // list memory is written only while an append is finishing
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_APPEND && ptr_we && ptr_wa == cur_k))
    else $error("list write without matching pointer update");

  // clear never meets a pointer write-back
  assert property (@(posedge clk) disable iff (rst)
    !(ptr_we && ptr_clr))
    else $error("pointer write during clear");

  // every issued pointer read reaches the compare stage
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && s1_v) |=> s2_v)
    else $error("head read lost in scan");

  // a finished result waits in hold only behind a busy output
  assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> $past(rsp_valid))
    else $error("hold entered with free output");

endmodule

`default_nettype wire

### sim/tb_k_way_sorted_merge_core.sv
`timescale 1ns / 1ps

module tb_k_way_sorted_merge_core;
  import kwm_pkg::*;

  localparam int NUM_LISTS    = NUM_LISTS_DEF;
  localparam int LIST_DEPTH   = LIST_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  // a pop scans every list, so the wait before the verdict grows with NUM_LISTS
  localparam int DRAIN_CYCLES = 4 * (NUM_LISTS + 3) + 8;
  localparam int IDLE_PCT     = 11;
  localparam int MAX_REPORTS  = 40;
  // the one command code the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // shadow copy of the lists: circular buffers with head and fill count
  logic signed [31:0] list_mem [NUM_LISTS][LIST_DEPTH];
  int   list_head [NUM_LISTS];
  int   list_fill [NUM_LISTS];

  // responses still owed by the block, oldest first
  rsp_t pending_rsp [$];
  rsp_t next_rsp;

  int   error_count = 0;
  int   cycle_count = 0;
  int   req_count   = 0;
  int   hold_left   = 0;
  bit   quiet       = 1'b0;

  k_way_sorted_merge_core #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // applies one request to the shadow lists and returns the response it owes
  function automatic rsp_t predict_merge(req_t r);
    rsp_t res;
    int   idx;
    int   best;
    res  = '0;
    idx  = int'(r.list_index);
    best = -1;
    case (r.cmd)
      CMD_APPEND: begin
        if (idx >= NUM_LISTS || list_fill[idx] >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_mem[idx][(list_head[idx] + list_fill[idx]) % LIST_DEPTH] = r.value;
          list_fill[idx]++;
        end
      end
      CMD_POP: begin
        // strict compare keeps the lowest list on equal heads
        for (int k = 0; k < NUM_LISTS; k++) begin
          if (list_fill[k] != 0 &&
              (best < 0 || list_mem[k][list_head[k]] < list_mem[best][list_head[best]]))
            best = k;
        end
        if (best < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.merged_value = list_mem[best][list_head[best]];
          res.source_list  = 3'(best);
          list_head[best]  = (list_head[best] + 1) % LIST_DEPTH;
          list_fill[best]--;
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < NUM_LISTS; k++) begin
          list_head[k] = 0;
          list_fill[k] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t: mismatch in %s, got %0h, want %0h", $time, what, got, want);
    error_count++;
  endtask

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_request(logic [1:0] cmd, logic [2:0] idx, logic signed [31:0] val);
    req_t r;
    r.cmd        = cmd;
    r.list_index = idx;
    r.value      = val;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(predict_merge(r));
    if (cmd != CMD_NONE) req_count++;
  endtask

  // sender goes quiet until every owed response is back
  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // receiver: long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // response checker: field by field against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", rsp.merged_value, '0);
      end else begin
        next_rsp = pending_rsp.pop_front();
        if (rsp.status !== next_rsp.status)
          report_mismatch("status", rsp.status, next_rsp.status);
        if (rsp.merged_value !== next_rsp.merged_value)
          report_mismatch("merged_value", rsp.merged_value, next_rsp.merged_value);
        if (rsp.source_list !== next_rsp.source_list)
          report_mismatch("source_list", rsp.source_list, next_rsp.source_list);
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_POP, 3'd5, 32'sd17);            // nothing stored yet
    send_request(CMD_APPEND, 3'd0, 32'sh8000_0000);  // most negative
    send_request(CMD_APPEND, 3'd7, 32'sh7fff_ffff);  // most positive
    send_request(CMD_APPEND, 3'd3, 32'sd0);
    send_request(CMD_APPEND, 3'd5, -32'sd1);
    repeat (4) send_request(CMD_POP, 3'd0, 32'sd0);
    // equal heads, lowest list wins
    send_request(CMD_APPEND, 3'd6, 32'sd5);
    send_request(CMD_APPEND, 3'd2, 32'sd5);
    send_request(CMD_APPEND, 3'd4, 32'sd5);
    repeat (3) send_request(CMD_POP, 3'd7, 32'sh7fff_ffff);
    // list not in order: the head goes first regardless
    send_request(CMD_APPEND, 3'd1, 32'sd9);
    send_request(CMD_APPEND, 3'd1, 32'sd3);
    repeat (2) send_request(CMD_POP, 3'd0, 32'sd0);
    send_request(CMD_NONE, 3'd7, 32'shffff_ffff);
    send_request(CMD_POP, 3'd0, 32'sd0);
    // clear drops what is held
    send_request(CMD_APPEND, 3'd0, 32'sd1);
    send_request(CMD_CLEAR, 3'd2, 32'sh5555_aaaa);
    send_request(CMD_POP, 3'd0, 32'sd0);
  endtask

  task automatic test_full_list();
    int idx;
    logic signed [31:0] v;
    idx = $urandom_range(NUM_LISTS - 1);
    v   = -32'sd1000;
    while (list_fill[idx] < LIST_DEPTH) begin
      send_request(CMD_APPEND, 3'(idx), v);
      v = v + 32'sd7;
    end
    send_request(CMD_APPEND, 3'(idx), 32'sd0);        // dropped
    send_request(CMD_APPEND, 3'(idx), 32'($urandom)); // dropped
    repeat (3) send_request(CMD_POP, 3'($urandom), 32'($urandom));
    send_request(CMD_APPEND, 3'(idx), v);             // wraps the write side
    send_request(CMD_CLEAR, 3'd0, 32'sd0);
  endtask

  task automatic test_backpressure();
    // receiver holds off while requests keep coming, so the input stalls
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++)
      send_request((i % 3 == 2) ? CMD_POP : CMD_APPEND, 3'(i), 32'($urandom));
    drain_responses();
    for (int i = 0; i < 12; i++)
      send_request((i % 2 == 1) ? CMD_POP : CMD_APPEND, 3'($urandom), 32'($urandom));
  endtask

  task automatic test_random();
    int start;
    int mode;
    int nl;
    int n;
    int idx;
    int pops;
    logic signed [31:0] v;
    start = req_count;
    while (req_count - start < RANDOM_ITEMS) begin
      // one long stretch with no idling on either side
      quiet = (req_count - start >= 300 && req_count - start < 500);
      mode  = $urandom_range(99);
      if (mode < 60) begin
        // sorted runs into a few lists, then merge them out
        pops = 0;
        nl   = $urandom_range(NUM_LISTS, 1);
        for (int l = 0; l < nl; l++) begin
          idx = $urandom_range(NUM_LISTS - 1);
          n   = $urandom_range(8, 1);
          if ($urandom_range(1) == 1) v = 32'($urandom);
          else v = 32'($urandom_range(40)) - 32'sd20;
          for (int j = 0; j < n; j++) begin
            send_request(CMD_APPEND, 3'(idx), v);
            pops++;
            v = v + 32'($urandom_range(3));
            if ($urandom_range(99) < 15) begin
              send_request(CMD_POP, 3'($urandom), 32'($urandom));
              pops--;
            end
          end
        end
        if ($urandom_range(99) < 10) begin
          send_request(CMD_CLEAR, 3'($urandom), 32'($urandom));
        end else begin
          pops += $urandom_range(2);
          repeat (pops) send_request(CMD_POP, 3'($urandom), 32'($urandom));
        end
      end else if (mode < 72) begin
        // fill one list to the brim and push past it
        idx = $urandom_range(NUM_LISTS - 1);
        v   = 32'($urandom);
        while (list_fill[idx] < LIST_DEPTH) begin
          send_request(CMD_APPEND, 3'(idx), v);
          v = v + 32'($urandom_range(100));
        end
        repeat ($urandom_range(3, 1)) send_request(CMD_APPEND, 3'(idx), 32'($urandom));
      end else begin
        // noise: any command, any index, any value
        if ($urandom_range(1) == 1) v = 32'($urandom);
        else v = 32'($urandom_range(8)) - 32'sd4;
        send_request(2'($urandom_range(3)), 3'($urandom), v);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random();
    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/kwm_pkg.sv
design/kwm_list_ram.sv
design/kwm_ptr_table.sv
design/k_way_sorted_merge_core.sv
sim/tb_k_way_sorted_merge_core.sv
